[rtl/core/sorted_insertion_buffer_core_assert.svh]
// Assertion macros for the sorted insertion buffer.
`ifndef SORTED_INSERTION_BUFFER_CORE_ASSERT_SVH
`define SORTED_INSERTION_BUFFER_CORE_ASSERT_SVH

// Property checked on every rising clock edge, off during reset.
`define SIB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value while a request stalls.
`define SIB_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        cond |=> $stable(sig)) else $error(msg);

`endif

[rtl/core/sib_pkg.sv]
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and constants of the sorted insertion buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 64;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

    // Non-NaN double pattern to an unsigned code of the same order.
    function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] r;
        if (b[KEY_W-2:0] == '0)
            r = {1'b1, {(KEY_W-1){1'b0}}};
        else if (b[KEY_W-1])
            r = ~b;
        else
            r = b | {1'b1, {(KEY_W-1){1'b0}}};
        return r;
    endfunction

    function automatic logic is_nan(input logic [KEY_W-1:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    endfunction

endpackage

[rtl/core/sib_stream_if.sv]
// ----------------------------------------------------------------------------
// sib_stream_if
// Valid/ready channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface sib_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sib_cell.sv]
// ----------------------------------------------------------------------------
// sib_cell
// One chain slot: holds a key, compares, shifts toward the tail or the head.
// ----------------------------------------------------------------------------
module sib_cell (
    input  logic                      clk,
    input  logic [sib_pkg::KEY_W-1:0] new_key,
    input  logic                      live,
    input  logic                      left_found,
    input  logic [sib_pkg::KEY_W-1:0] left_key,
    input  logic                      ins,
    input  logic                      drain_shift,
    input  logic [sib_pkg::KEY_W-1:0] right_key,
    output logic                      found,
    output logic [sib_pkg::KEY_W-1:0] key
);
    logic [sib_pkg::KEY_W-1:0] key_reg;
    logic [sib_pkg::KEY_W-1:0] key_next;
    logic                      gt;

    // an empty cell counts as greater so the key lands at the fill end
    assign gt = !live
                || (!sib_pkg::is_nan(key_reg) && !sib_pkg::is_nan(new_key)
                    && (sib_pkg::order_code(key_reg) > sib_pkg::order_code(new_key)));
    assign found = left_found || gt;
    assign key   = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (drain_shift)
            key_next = right_key;
        else if (ins)
        begin
            if (left_found)
                key_next = left_key;
            else if (gt)
                key_next = new_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end
endmodule

[rtl/core/sorted_insertion_buffer_core.sv]
// ----------------------------------------------------------------------------
// sorted_insertion_buffer_core
// Ascending store of IEEE double keys in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// On an insert request every cell compares its key with the new one, the new
// key lands in front of the first stored key that is greater, and that key and
// all keys behind it move one place toward the tail. Once taken, a drain
// request streams the stored keys in order, one per cycle unless the result
// side stalls, from the head cell as the chain shifts toward the head, so it
// holds the input off until the last key has left the chain; no request is
// taken while a drain runs. Each result carries the sticky overflow flag, set
// when an insert arrives while all CAPACITY cells are full.
module sorted_insertion_buffer_core #(
    parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    sib_stream_if.sink   in_ch,
    sib_stream_if.source out_ch
);
    localparam int CW = $clog2(CAPACITY + 1);

    sib_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   left_reg, left_next;
    logic            ov_valid_reg, ov_valid_next;
    logic [sib_pkg::KEY_W-1:0] ov_key_reg;
    logic            ov_last_reg, ov_ovf_reg;

    logic [sib_pkg::KEY_W-1:0] keys [CAPACITY];
    logic [CAPACITY-1:0]       found;
    logic [CAPACITY-1:0]       live;
    sib_pkg::cell_ctrl_t       ctrl;
    logic                      in_fire, out_free, emit;

    assign out_free = !ov_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == sib_pkg::ST_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign emit = (state_reg == sib_pkg::ST_DRAIN) && out_free;

    always_comb
    begin
        ctrl.ins   = in_fire && (in_ch.data.req_type == sib_pkg::REQ_INSERT)
                     && (cnt_reg != CW'(CAPACITY));
        ctrl.shift = emit;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic lf;
            logic [sib_pkg::KEY_W-1:0] lk, rk;
            assign live[g] = (CW'(g) < cnt_reg);
            if (g == 0)
            begin : g_h
                assign lf = 1'b0;
                assign lk = '0;
            end
            else
            begin : g_b
                assign lf = found[g-1];
                assign lk = keys[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_t
                assign rk = '0;
            end
            else
            begin : g_r
                assign rk = keys[g+1];
            end
            sib_cell u_cell (
                .clk(clk), .new_key(in_ch.data.key_bits), .live(live[g]),
                .left_found(lf), .left_key(lk), .ins(ctrl.ins),
                .drain_shift(ctrl.shift), .right_key(rk),
                .found(found[g]), .key(keys[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        left_next = left_reg;
        case (state_reg)
            sib_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.data.req_type == sib_pkg::REQ_INSERT)
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                            ovf_next = 1'b1;
                        else
                            cnt_next = cnt_reg + CW'(1);
                    end
                    else if (cnt_reg != '0)
                    begin
                        state_next = sib_pkg::ST_DRAIN;
                        left_next = cnt_reg;
                        cnt_next = '0;
                    end
                end
            end
            sib_pkg::ST_DRAIN:
            begin
                if (emit)
                begin
                    left_next = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                        state_next = sib_pkg::ST_IDLE;
                end
            end
            default: state_next = sib_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_valid_next = ov_valid_reg;
        if (emit)
            ov_valid_next = 1'b1;
        else if (out_ch.ready)
            ov_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sib_pkg::ST_IDLE;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            left_reg <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            left_reg <= left_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ov_key_reg <= keys[0];
            ov_last_reg <= (left_reg == CW'(1));
            ov_ovf_reg <= ovf_reg;
        end
    end

    assign out_ch.valid = ov_valid_reg;
    assign out_ch.data.sorted_key = ov_key_reg;
    assign out_ch.data.last = ov_last_reg;
    assign out_ch.data.overflow = ov_ovf_reg;
endmodule

[rtl/core/sib_checker.sv]
// ----------------------------------------------------------------------------
// sib_checker
// Port-level checks of the sorted insertion buffer.
// ----------------------------------------------------------------------------
`include "sorted_insertion_buffer_core_assert.svh"

module sib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic        out_overflow,
    input logic [63:0] out_key
);
    `SIB_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid && !out_ready, out_key, "result changed while stalled")
    `SIB_ASSERT(a_ovf_sticky, clk, rst_n, out_valid && out_ready && out_overflow && !out_last |=> !out_valid || out_overflow, "overflow flag dropped within a drain")
    `SIB_ASSERT(a_busy, clk, rst_n, out_valid && out_ready && !out_last |-> !in_ready, "request taken mid drain")
endmodule

bind sorted_insertion_buffer_core sib_checker u_sib_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.data.last), .out_overflow(out_ch.data.overflow),
    .out_key(out_ch.data.sorted_key)
);

[verif/sib_tb_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_tb_stream_if
// Payload types for the request and result channels of the sorted insertion
// buffer test.
// ----------------------------------------------------------------------------
package sib_tb_pkg;

    typedef struct packed {
        logic        req_type;
        logic [63:0] key_bits;
    } sib_req_t;

    typedef struct packed {
        logic [63:0] sorted_key;
        logic        last;
        logic        overflow;
    } sib_res_t;

endpackage

[verif/tb_sorted_insertion_buffer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insertion_buffer_core
// Drives insert and drain requests with random gaps and stalls, keeps a
// sorted key list of its own and checks every drained key field by field.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_buffer_core;

    localparam int DEPTH      = sib_pkg::CAPACITY_DEF;
    localparam int CYCLE_CAP  = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sib_stream_if #(.T(sib_tb_pkg::sib_req_t)) in_ch ();
    sib_stream_if #(.T(sib_tb_pkg::sib_res_t)) out_ch ();

    sorted_insertion_buffer_core #(.CAPACITY(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #6 clk = ~clk;

    sib_tb_pkg::sib_req_t pending_reqs[$];
    sib_tb_pkg::sib_res_t drained_due[$];
    logic [63:0]          held_keys[$];
    bit                   sticky_drop;
    int                   errors;
    int                   cycles;
    int                   reqs_taken;
    int                   keys_checked;
    int                   drains_seen;
    bit                   gaps_on;
    bit                   stim_done;

    bit                   cur_valid;
    sib_tb_pkg::sib_req_t cur_req;
    int                   send_gap;
    int                   recv_stall;
    bit                   in_acc;
    bit                   out_acc;

    function automatic bit is_nan_key(logic [63:0] k);
        return (&k[62:52]) && (|k[51:0]);
    endfunction

    // IEEE a > b on bit patterns
    function automatic bit key_above(logic [63:0] a, logic [63:0] b);
        if (is_nan_key(a) || is_nan_key(b))
            return 1'b0;
        if (a[62:0] == '0 && b[62:0] == '0)
            return 1'b0;
        if (a[63] != b[63])
            return b[63];
        if (!a[63])
            return a[62:0] > b[62:0];
        return a[62:0] < b[62:0];
    endfunction

    function automatic void model_request(sib_tb_pkg::sib_req_t r);
        int pos;
        sib_tb_pkg::sib_res_t x;
        if (r.req_type == sib_pkg::REQ_INSERT)
        begin
            if (held_keys.size() >= DEPTH)
            begin
                sticky_drop = 1'b1;
                return;
            end
            pos = held_keys.size();
            for (int i = 0; i < held_keys.size(); i++)
                if (key_above(held_keys[i], r.key_bits))
                begin
                    pos = i;
                    break;
                end
            held_keys.insert(pos, r.key_bits);
        end
        else
        begin
            foreach (held_keys[i])
            begin
                x.sorted_key = held_keys[i];
                x.last       = (i == held_keys.size() - 1);
                x.overflow   = sticky_drop;
                drained_due.push_back(x);
            end
            held_keys.delete();
        end
    endfunction

    function automatic logic [63:0] pick_key();
        logic [63:0] pool[12] = '{64'h0, 64'h8000_0000_0000_0000,
            64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
            64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
            64'h4000_0000_0000_0000, 64'h8000_0000_0000_0001};
        case ($urandom_range(0, 3))
            0: return pool[$urandom_range(0, 11)];
            1: return {$urandom_range(0, 1) ? 12'h400 : 12'hC00, 49'd0,
                       3'($urandom_range(0, 7))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_insert(logic [63:0] k);
        sib_tb_pkg::sib_req_t r;
        r.req_type = sib_pkg::REQ_INSERT;
        r.key_bits = k;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_drain();
        sib_tb_pkg::sib_req_t r;
        r.req_type = sib_pkg::REQ_DRAIN;
        r.key_bits = {$urandom, $urandom};
        pending_reqs.push_back(r);
    endtask

    // monitor
    always @(posedge clk)
    begin
        in_acc  <= rst_n && in_ch.valid && in_ch.ready;
        out_acc <= rst_n && out_ch.valid && out_ch.ready;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                model_request(in_ch.data);
                reqs_taken <= reqs_taken + 1;
                if (in_ch.data.req_type == sib_pkg::REQ_DRAIN)
                    drains_seen <= drains_seen + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                keys_checked <= keys_checked + 1;
                if (drained_due.size() == 0)
                begin
                    $error("unexpected result key %h", out_ch.data.sorted_key);
                    errors++;
                end
                else
                begin
                    if (out_ch.data.sorted_key !== drained_due[0].sorted_key)
                    begin
                        $error("sorted_key expected %h actual %h",
                               drained_due[0].sorted_key, out_ch.data.sorted_key);
                        errors++;
                    end
                    if (out_ch.data.last !== drained_due[0].last)
                    begin
                        $error("last expected %b actual %b",
                               drained_due[0].last, out_ch.data.last);
                        errors++;
                    end
                    if (out_ch.data.overflow !== drained_due[0].overflow)
                    begin
                        $error("overflow expected %b actual %b",
                               drained_due[0].overflow, out_ch.data.overflow);
                        errors++;
                    end
                    void'(drained_due.pop_front());
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cur_valid && in_acc)
            begin
                cur_valid = 1'b0;
                send_gap  = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (!cur_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    cur_req   = pending_reqs.pop_front();
                    cur_valid = 1'b1;
                end
            end
            in_ch.valid <= cur_valid;
            in_ch.data  <= cur_req;
        end
    end

    // result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_acc)
                recv_stall = gaps_on ? $urandom_range(0, 11) : 0;
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int n;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cur_valid    = 1'b0;
        cur_req      = '0;
        send_gap     = 0;
        recv_stall   = 0;
        gaps_on      = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_drain();
        queue_insert(64'h7FF0_0000_0000_0000);
        queue_insert(64'hFFF0_0000_0000_0000);
        queue_insert(64'h7FF8_0000_0000_0001);
        queue_insert(64'h0);
        queue_insert(64'h8000_0000_0000_0000);
        queue_insert(64'h0000_0000_0000_0001);
        queue_insert(64'h3FF0_0000_0000_0000);
        queue_insert(64'hFFFF_FFFF_FFFF_FFFF);
        queue_insert(64'h7FEF_FFFF_FFFF_FFFF);
        queue_insert(64'h3FF0_0000_0000_0000);
        queue_insert(64'h8000_0000_0000_0001);
        queue_drain();
        queue_drain();
        queue_insert(64'h5555_5555_5555_5555);
        queue_drain();

        n = 0;
        while (n < 420)
        begin
            int batch = $urandom_range(0, 3) == 0 ? $urandom_range(20, 32)
                                                  : $urandom_range(0, 10);
            for (int i = 0; i < batch; i++)
                queue_insert(pick_key());
            queue_drain();
            n += batch + 1;
        end
        for (int i = 0; i < DEPTH + 3; i++)
            queue_insert(pick_key());
        queue_drain();
        queue_insert(pick_key());
        queue_drain();

        wait (pending_reqs.size() == 0 && !cur_valid);
        wait (drained_due.size() == 0);
        repeat (DEPTH + 20) @(posedge clk);
        stim_done = 1'b1;
        $display("Checked %0d keys over %0d drains from %0d requests.",
                 keys_checked, drains_seen, reqs_taken);
        if (errors == 0)
            $display("tb_sorted_insertion_buffer_core passed");
        else
            $display("tb_sorted_insertion_buffer_core failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            repeat (150) @(posedge clk);
            gaps_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_CAP);
        if (!stim_done)
        begin
            $display("tb_sorted_insertion_buffer_core failed");
            $finish;
        end
    end

endmodule
